// ===== rtl/frame_presentation_index_core_defines.svh =====
// Assertion macros shared by the frame presentation index RTL.
`ifndef FRAME_PRESENTATION_INDEX_CORE_DEFINES_SVH
`define FRAME_PRESENTATION_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpi_pkg.sv =====
// Shared constants, codes and types of the frame presentation index.
package fpi_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int DTS_W   = 40;
    localparam int OFF_W   = 32;
    localparam int QT_W    = 63;
    localparam int TIME_W  = 64;
    localparam int SCALE_W = 32;
    localparam int TPS_W   = 24;

    localparam int MAG_W    = DTS_W + 1;
    localparam int MUL_LO_W = 21;
    localparam int PROD_W   = MAG_W + TPS_W;
    localparam int STEP_W   = $clog2(PROD_W);

    localparam logic [SCALE_W-1:0] SCALE_RESET   = 32'd90000;
    localparam logic [TPS_W-1:0]   TICKS_PER_SEC = 24'd10000000;
    localparam logic [TIME_W-1:0]  TIME_MAX      = {1'b0, {(TIME_W-1){1'b1}}};

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY     = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DISPATCH,
        OP_LOAD_WRITE,
        OP_BUILD_INIT,
        OP_BUILD_DONE,
        OP_READ_I,
        OP_SWEEP_INIT,
        OP_SWEEP,
        OP_BUILD_WRITE,
        OP_PROBE_RD,
        OP_PROBE_UPD,
        OP_EDGE,
        OP_NEIGH_A,
        OP_NEIGH_B,
        OP_KEY_RD1,
        OP_KEY_RD2,
        OP_KEY_RES,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              last;
        logic              searchable;
        logic              load_full;
        logic              tick_done;
        logic              i_end;
        logic              sweep_done;
        logic              q_open;
        logic              edge_hit;
        logic              out_free;
    } t_stat;

endpackage

// ===== rtl/fpi_in_if.sv =====
// Input item channel: valid/ready handshake with the query and load fields.
interface fpi_in_if;
    import fpi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [DTS_W-1:0]         decode_time;
    logic signed [OFF_W-1:0]  composition_offset;
    logic                     is_keyframe;
    logic                     last_frame;
    logic signed [QT_W-1:0]   query_time;
    logic [IDX_W-1:0]         query_frame;

    modport source (
        output valid, mode, decode_time, composition_offset, is_keyframe,
               last_frame, query_time, query_frame,
        input  ready
    );
    modport sink (
        input  valid, mode, decode_time, composition_offset, is_keyframe,
               last_frame, query_time, query_frame,
        output ready
    );
endinterface

// ===== rtl/fpi_out_if.sv =====
// Result channel: valid/ready handshake with frame index and status.
interface fpi_out_if;
    import fpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  item_index;
    logic [STAT_W-1:0] status;

    modport source (output valid, item_index, status, input ready);
    modport sink (input valid, item_index, status, output ready);
endinterface

// ===== rtl/fpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fpi_ticks.sv =====
// Decode time plus offset to 100 ns ticks: split multiply, then bit-serial divide.
module fpi_ticks (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fpi_pkg::DTS_W-1:0]        i_decode_time,
    input  logic signed [fpi_pkg::OFF_W-1:0] i_offset,
    input  logic [fpi_pkg::SCALE_W-1:0]      i_scale,
    output logic                             o_done,
    output logic [fpi_pkg::TIME_W-1:0]       o_ticks
);
    import fpi_pkg::*;

    typedef enum logic [2:0] {T_IDLE, T_MUL_LO, T_MUL_HI, T_DIV, T_DONE} t_tstate;

    t_tstate              r_state;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic [SCALE_W-1:0]   r_div;
    logic [PROD_W-1:0]    r_acc;
    logic [SCALE_W-1:0]   r_rem;
    logic [STEP_W-1:0]    r_cnt;

    logic signed [DTS_W+1:0] sum;
    logic [DTS_W+1:0]        sum_mag;
    logic [PROD_W-1:0]       p_lo;
    logic [PROD_W-1:0]       p_hi;
    logic [PROD_W-1:0]       prod_sum;
    logic [SCALE_W:0]        rem_sh;
    logic                    rem_ge;
    logic [SCALE_W:0]        rem_nx;

    assign sum     = $signed({2'b00, i_decode_time}) + (DTS_W + 2)'(i_offset);
    assign sum_mag = sum[DTS_W+1] ? (-sum) : sum;

    assign p_lo = PROD_W'(r_mag[MUL_LO_W-1:0]) * PROD_W'(TICKS_PER_SEC);
    assign p_hi = PROD_W'(r_mag[MAG_W-1:MUL_LO_W]) * PROD_W'(TICKS_PER_SEC);
    assign prod_sum = r_acc + (p_hi << MUL_LO_W);

    // restoring divide: dividend bits leave the top of r_acc, quotient bits enter below
    assign rem_sh = {r_rem, r_acc[PROD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        r_mag   <= sum_mag[MAG_W-1:0];
                        r_neg   <= sum[DTS_W+1];
                        r_div   <= (i_scale == '0) ? SCALE_W'(1) : i_scale;
                        r_state <= T_MUL_LO;
                    end
                end
                T_MUL_LO: begin
                    r_acc   <= p_lo;
                    r_state <= T_MUL_HI;
                end
                T_MUL_HI: begin
                    // wrap the product to 64 bits before dividing
                    r_acc   <= {1'b0, prod_sum[TIME_W-1:0]};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= T_DIV;
                end
                T_DIV: begin
                    r_rem <= rem_nx[SCALE_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], rem_ge};
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(PROD_W - 1)) begin
                        r_state <= T_DONE;
                    end
                end
                T_DONE: begin
                    r_state <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == T_DONE);

    // saturate positive quotients above the signed 64-bit range
    always_comb begin
        if (r_neg) begin
            o_ticks = -r_acc[TIME_W-1:0];
        end else if (|r_acc[PROD_W-1:TIME_W-1]) begin
            o_ticks = TIME_MAX;
        end else begin
            o_ticks = r_acc[TIME_W-1:0];
        end
    end
endmodule

// ===== rtl/fpi_ctrl.sv =====
// Controller: sequences load, build, nearest-time and keyframe operations.
module fpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fpi_pkg::t_stat i_stat,
    output fpi_pkg::t_op   o_op
);
    import fpi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_CONV, S_L_WRITE,
        S_B_INIT, S_B_OUTER, S_B_TI, S_B_SWEEP, S_B_WRITE,
        S_Q_PROBE, S_Q_CMP, S_Q_A, S_Q_B,
        S_K_RD1, S_K_RD2, S_K_RES,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_op = OP_DISPATCH;
                case (i_stat.mode)
                    MODE_LOAD: begin
                        if (!i_stat.load_full) begin
                            n_state = S_CONV;
                        end else if (i_stat.last) begin
                            n_state = S_B_INIT;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    MODE_NEAREST: n_state = i_stat.searchable ? S_Q_PROBE : S_FINISH;
                    MODE_KEY:     n_state = i_stat.searchable ? S_K_RD1 : S_FINISH;
                    default:      n_state = S_FINISH;
                endcase
            end
            S_CONV: begin
                if (i_stat.tick_done) begin
                    n_state = S_L_WRITE;
                end
            end
            S_L_WRITE: begin
                o_op    = OP_LOAD_WRITE;
                n_state = i_stat.last ? S_B_INIT : S_FINISH;
            end
            S_B_INIT: begin
                o_op    = OP_BUILD_INIT;
                n_state = S_B_OUTER;
            end
            S_B_OUTER: begin
                if (i_stat.i_end) begin
                    o_op    = OP_BUILD_DONE;
                    n_state = S_FINISH;
                end else begin
                    o_op    = OP_READ_I;
                    n_state = S_B_TI;
                end
            end
            S_B_TI: begin
                o_op    = OP_SWEEP_INIT;
                n_state = S_B_SWEEP;
            end
            S_B_SWEEP: begin
                o_op = OP_SWEEP;
                if (i_stat.sweep_done) begin
                    n_state = S_B_WRITE;
                end
            end
            S_B_WRITE: begin
                o_op    = OP_BUILD_WRITE;
                n_state = S_B_OUTER;
            end
            S_Q_PROBE: begin
                if (i_stat.q_open) begin
                    o_op    = OP_PROBE_RD;
                    n_state = S_Q_CMP;
                end else begin
                    o_op    = OP_EDGE;
                    n_state = i_stat.edge_hit ? S_FINISH : S_Q_A;
                end
            end
            S_Q_CMP: begin
                o_op    = OP_PROBE_UPD;
                n_state = S_Q_PROBE;
            end
            S_Q_A: begin
                o_op    = OP_NEIGH_A;
                n_state = S_Q_B;
            end
            S_Q_B: begin
                o_op    = OP_NEIGH_B;
                n_state = S_FINISH;
            end
            S_K_RD1: begin
                o_op    = OP_KEY_RD1;
                n_state = S_K_RD2;
            end
            S_K_RD2: begin
                o_op    = OP_KEY_RD2;
                n_state = S_K_RES;
            end
            S_K_RES: begin
                o_op    = OP_KEY_RES;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

// ===== rtl/fpi_dp.sv =====
// Datapath: frame stores, rank sort, binary search, keyframe lookup, result register.
module fpi_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpi_pkg::t_op                      i_op,
    output fpi_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_we,
    input  logic [fpi_pkg::SCALE_W-1:0]       i_cfg_wdata,
    input  logic [fpi_pkg::MODE_W-1:0]        i_mode,
    input  logic [fpi_pkg::DTS_W-1:0]         i_decode_time,
    input  logic signed [fpi_pkg::OFF_W-1:0]  i_composition_offset,
    input  logic                              i_is_keyframe,
    input  logic                              i_last_frame,
    input  logic signed [fpi_pkg::QT_W-1:0]   i_query_time,
    input  logic [fpi_pkg::IDX_W-1:0]         i_query_frame,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [fpi_pkg::IDX_W-1:0]         o_item_index,
    output logic [fpi_pkg::STAT_W-1:0]        o_status
);
    import fpi_pkg::*;

    // control state
    logic [SCALE_W-1:0] r_scale,     n_scale;
    logic [CNT_W-1:0]   r_total,     n_total;
    logic               r_ready,     n_ready;
    logic               r_any,       n_any;
    logic               r_have_key,  n_have_key;
    logic               r_out_valid, n_out_valid;

    // payload
    logic [MODE_W-1:0]       r_mode,  n_mode;
    logic [DTS_W-1:0]        r_dts,   n_dts;
    logic signed [OFF_W-1:0] r_off,   n_off;
    logic                    r_key,   n_key;
    logic                    r_last,  n_last;
    logic signed [TIME_W-1:0] r_qt,   n_qt;
    logic [IDX_W-1:0]        r_qf,    n_qf;
    logic [IDX_W-1:0]        r_last_key,  n_last_key;
    logic [IDX_W-1:0]        r_first_key, n_first_key;
    logic [CNT_W-1:0]        r_i,    n_i;
    logic [CNT_W-1:0]        r_k,    n_k;
    logic [CNT_W-1:0]        r_pk,   n_pk;
    logic                    r_pend, n_pend;
    logic [CNT_W-1:0]        r_rank, n_rank;
    logic [CNT_W-1:0]        r_lo,   n_lo;
    logic [CNT_W-1:0]        r_hi,   n_hi;
    logic [CNT_W-1:0]        r_mid,  n_mid;
    logic [TIME_W-1:0]       r_ti,   n_ti;
    logic [TIME_W-1:0]       r_sa,   n_sa;
    logic [IDX_W-1:0]        r_res_idx, n_res_idx;
    logic [STAT_W-1:0]       r_res_st,  n_res_st;
    logic [IDX_W-1:0]        r_out_idx, n_out_idx;
    logic [STAT_W-1:0]       r_out_st,  n_out_st;

    // memory ports
    logic               ft_we, st_we, po_we, kb_we;
    logic [IDX_W-1:0]   ft_waddr, ft_raddr, st_waddr, st_raddr;
    logic [IDX_W-1:0]   po_waddr, po_raddr, kb_waddr, kb_raddr;
    logic [TIME_W-1:0]  ft_wdata, ft_rdata, st_wdata, st_rdata;
    logic [IDX_W-1:0]   po_wdata, po_rdata;
    logic [IDX_W:0]     kb_wdata, kb_rdata;

    logic               tick_start;
    logic               tick_done;
    logic [TIME_W-1:0]  tick_value;

    logic               load_full;
    logic [CNT_W-1:0]   total_m1;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic               sw_lt;
    logic               sw_eq;
    logic [TIME_W-1:0]  below;
    logic [TIME_W-1:0]  above;

    assign load_full = !r_ready && (r_total == CNT_W'(MAX_FRAMES));
    assign total_m1  = r_total - CNT_W'(1);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[CNT_W:1];
    assign sw_lt     = $signed(ft_rdata) < $signed(r_ti);
    assign sw_eq     = ft_rdata == r_ti;
    assign below     = r_qt - r_sa;
    assign above     = st_rdata - r_qt;

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.last       = r_last;
        o_stat.searchable = r_ready && (r_total != '0);
        o_stat.load_full  = load_full;
        o_stat.tick_done  = tick_done;
        o_stat.i_end      = (r_i == r_total);
        o_stat.sweep_done = (r_k == r_total) && !r_pend;
        o_stat.q_open     = r_lo < r_hi;
        o_stat.edge_hit   = (r_lo == '0) || (r_lo == r_total);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_scale     = i_cfg_we ? i_cfg_wdata : r_scale;
        n_total     = r_total;
        n_ready     = r_ready;
        n_any       = r_any;
        n_have_key  = r_have_key;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        n_mode      = r_mode;
        n_dts       = r_dts;
        n_off       = r_off;
        n_key       = r_key;
        n_last      = r_last;
        n_qt        = r_qt;
        n_qf        = r_qf;
        n_last_key  = r_last_key;
        n_first_key = r_first_key;
        n_i         = r_i;
        n_k         = r_k;
        n_pk        = r_pk;
        n_pend      = r_pend;
        n_rank      = r_rank;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_ti        = r_ti;
        n_sa        = r_sa;
        n_res_idx   = r_res_idx;
        n_res_st    = r_res_st;
        n_out_idx   = r_out_idx;
        n_out_st    = r_out_st;
        tick_start  = 1'b0;
        ft_we = 1'b0; ft_waddr = r_total[IDX_W-1:0]; ft_wdata = tick_value; ft_raddr = '0;
        kb_we = 1'b0; kb_waddr = r_total[IDX_W-1:0]; kb_raddr = '0;
        kb_wdata = {r_key || r_have_key, r_key ? r_total[IDX_W-1:0] : r_last_key};
        st_we = 1'b0; st_waddr = r_rank[IDX_W-1:0]; st_wdata = r_ti; st_raddr = '0;
        po_we = 1'b0; po_waddr = r_rank[IDX_W-1:0]; po_wdata = r_i[IDX_W-1:0]; po_raddr = '0;

        case (i_op)
            OP_CAPTURE: begin
                n_mode = i_mode;
                n_dts  = i_decode_time;
                n_off  = i_composition_offset;
                n_key  = i_is_keyframe;
                n_last = i_last_frame;
                n_qt   = TIME_W'(i_query_time);
                n_qf   = i_query_frame;
            end
            OP_DISPATCH: begin
                // a load after a build starts a new clip
                if (r_mode == MODE_LOAD && r_ready) begin
                    n_total    = '0;
                    n_any      = 1'b0;
                    n_have_key = 1'b0;
                    n_ready    = 1'b0;
                end
                n_lo      = '0;
                n_hi      = r_total;
                n_res_idx = '0;
                n_res_st  = ST_EMPTY;
                if (r_mode == MODE_LOAD) begin
                    if (load_full) begin
                        n_res_idx = total_m1[IDX_W-1:0];
                        n_res_st  = ST_FULL;
                    end else begin
                        tick_start = 1'b1;
                    end
                end
            end
            OP_LOAD_WRITE: begin
                ft_we = 1'b1;
                kb_we = 1'b1;
                if (r_key) begin
                    n_last_key = r_total[IDX_W-1:0];
                    n_have_key = 1'b1;
                    n_any      = 1'b1;
                    if (!r_any) begin
                        n_first_key = r_total[IDX_W-1:0];
                    end
                end
                n_total   = r_total + CNT_W'(1);
                n_res_idx = r_total[IDX_W-1:0];
                n_res_st  = ST_OK;
            end
            OP_BUILD_INIT: n_i = '0;
            OP_BUILD_DONE: n_ready = 1'b1;
            OP_READ_I:     ft_raddr = r_i[IDX_W-1:0];
            OP_SWEEP_INIT: begin
                n_ti   = ft_rdata;
                n_k    = '0;
                n_rank = '0;
                n_pend = 1'b0;
            end
            OP_SWEEP: begin
                // rank = frames earlier in time, plus equal times earlier in decode order
                if (r_pend && (sw_lt || (sw_eq && r_pk < r_i))) begin
                    n_rank = r_rank + CNT_W'(1);
                end
                if (r_k != r_total) begin
                    ft_raddr = r_k[IDX_W-1:0];
                    n_pk     = r_k;
                    n_k      = r_k + CNT_W'(1);
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            OP_BUILD_WRITE: begin
                st_we = 1'b1;
                po_we = 1'b1;
                n_i   = r_i + CNT_W'(1);
            end
            OP_PROBE_RD: begin
                st_raddr = mid[IDX_W-1:0];
                n_mid    = mid;
            end
            OP_PROBE_UPD: begin
                if ($signed(st_rdata) < r_qt) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            OP_EDGE: begin
                n_res_st = ST_OK;
                if (r_lo == '0) begin
                    n_res_idx = '0;
                end else if (r_lo == r_total) begin
                    n_res_idx = total_m1[IDX_W-1:0];
                end
                st_raddr = IDX_W'(r_lo - CNT_W'(1));
            end
            OP_NEIGH_A: begin
                n_sa     = st_rdata;
                st_raddr = r_lo[IDX_W-1:0];
            end
            OP_NEIGH_B: begin
                // tie goes to the lower index
                n_res_idx = (below <= above) ? IDX_W'(r_lo - CNT_W'(1)) : r_lo[IDX_W-1:0];
                n_res_st  = ST_OK;
            end
            OP_KEY_RD1: po_raddr = r_qf;
            OP_KEY_RD2: kb_raddr = (CNT_W'(r_qf) < r_total) ? po_rdata : '0;
            OP_KEY_RES: begin
                n_res_st = ST_OK;
                if (!r_any) begin
                    n_res_idx = '0;
                end else if (kb_rdata[IDX_W]) begin
                    n_res_idx = kb_rdata[IDX_W-1:0];
                end else begin
                    n_res_idx = r_first_key;
                end
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_idx   = r_res_idx;
                n_out_st    = r_res_st;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RESET;
            r_total     <= '0;
            r_ready     <= 1'b0;
            r_any       <= 1'b0;
            r_have_key  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scale     <= n_scale;
            r_total     <= n_total;
            r_ready     <= n_ready;
            r_any       <= n_any;
            r_have_key  <= n_have_key;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_dts       <= n_dts;
        r_off       <= n_off;
        r_key       <= n_key;
        r_last      <= n_last;
        r_qt        <= n_qt;
        r_qf        <= n_qf;
        r_last_key  <= n_last_key;
        r_first_key <= n_first_key;
        r_i         <= n_i;
        r_k         <= n_k;
        r_pk        <= n_pk;
        r_pend      <= n_pend;
        r_rank      <= n_rank;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_ti        <= n_ti;
        r_sa        <= n_sa;
        r_res_idx   <= n_res_idx;
        r_res_st    <= n_res_st;
        r_out_idx   <= n_out_idx;
        r_out_st    <= n_out_st;
    end

    assign o_out_valid  = r_out_valid;
    assign o_item_index = r_out_idx;
    assign o_status     = r_out_st;

    fpi_ticks u_ticks (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (tick_start),
        .i_decode_time (r_dts),
        .i_offset      (r_off),
        .i_scale       (r_scale),
        .o_done        (tick_done),
        .o_ticks       (tick_value)
    );

    fpi_ram #(.WIDTH(TIME_W), .DEPTH(MAX_FRAMES)) u_frame_times (
        .i_clk (i_clk), .i_we (ft_we), .i_waddr (ft_waddr), .i_wdata (ft_wdata),
        .i_raddr (ft_raddr), .o_rdata (ft_rdata)
    );

    fpi_ram #(.WIDTH(TIME_W), .DEPTH(MAX_FRAMES)) u_sorted_times (
        .i_clk (i_clk), .i_we (st_we), .i_waddr (st_waddr), .i_wdata (st_wdata),
        .i_raddr (st_raddr), .o_rdata (st_rdata)
    );

    fpi_ram #(.WIDTH(IDX_W), .DEPTH(MAX_FRAMES)) u_present_order (
        .i_clk (i_clk), .i_we (po_we), .i_waddr (po_waddr), .i_wdata (po_wdata),
        .i_raddr (po_raddr), .o_rdata (po_rdata)
    );

    // per decode position: valid flag and last keyframe at or before it
    fpi_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_FRAMES)) u_key_before (
        .i_clk (i_clk), .i_we (kb_we), .i_waddr (kb_waddr), .i_wdata (kb_wdata),
        .i_raddr (kb_raddr), .o_rdata (kb_rdata)
    );
endmodule

// ===== rtl/frame_presentation_index_core.sv =====
// Load: two-step multiply, then 65-step bit-serial divide; one item at a time.
// Final load adds the rank sort of the N frames, one frame store read a cycle.
// Nearest query: binary search of the sorted store, each probe a read state then an update state.
// Keyframe query: two dependent store reads. Each result waits in an output register.
// Synchronous active-low reset empties the index and sets time_scale to 90000; no clearing pass.
`include "frame_presentation_index_core_defines.svh"

module frame_presentation_index_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fpi_pkg::SCALE_W-1:0] i_cfg_wdata,
    fpi_in_if.sink                      i_item,
    fpi_out_if.source                   o_result
);
    import fpi_pkg::*;

    t_op   op;
    t_stat stat;

    fpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_stat  (stat),
        .o_op    (op)
    );

    fpi_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_op                 (op),
        .o_stat               (stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_mode               (i_item.mode),
        .i_decode_time        (i_item.decode_time),
        .i_composition_offset (i_item.composition_offset),
        .i_is_keyframe        (i_item.is_keyframe),
        .i_last_frame         (i_item.last_frame),
        .i_query_time         (i_item.query_time),
        .i_query_frame        (i_item.query_frame),
        .i_out_ready          (o_result.ready),
        .o_out_valid          (o_result.valid),
        .o_item_index         (o_result.item_index),
        .o_status             (o_result.status)
    );

    `FPI_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready, "second transfer taken while busy")
    `FPI_ASSERT_IMP(a_full_index, i_clk, i_rst_n, o_result.valid && o_result.status == ST_FULL, o_result.item_index == IDX_W'(MAX_FRAMES - 1), "full status without last index")
    `FPI_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_result.valid && o_result.status == ST_EMPTY, o_result.item_index == '0, "empty status with nonzero index")
endmodule
